@@ rtl/rqf_pkg.sv @@
// Shared types and constants for the ring queue with front insert.
package rqf_pkg;

  // Width of the capacity register and of the entry count.
  localparam int CNT_W = 5;

  // Width of the data ports on the channels.
  localparam int PORT_DATA_W = 32;

  // Default store geometry.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Capacity after reset.
  localparam int CAP_RESET = 16;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP        = 3'd2,
    OP_PEEK       = 3'd3,
    OP_DROP       = 3'd4,
    OP_CLEAR      = 3'd5
  } rqf_op_t;

  // Status of one beat that waits for its store read data.
  typedef struct packed {
    logic             ok;
    logic             rd_hit;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } rqf_meta_t;

endpackage

@@ rtl/rqf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ring_queue_with_front_insert.sv @@
// Top level of the circular queue with push to back and push to front.
//
// The input channel carries one operation per beat (in_operation, in_item_data):
// push back, push front, pop, peek, drop front or clear. Every input beat gives
// exactly one result beat on the output channel: ok, the front word for a
// successful pop or peek (zero otherwise), and the entry count, empty and full
// flags after the operation.
// An input beat is accepted when in_valid is high and in_stall is low. Its result
// reaches the output through the waiting-beat register and the output register:
// the slot store is read in the accept cycle, and its registered read data is
// folded into the output register when the waiting beat moves on. One item can be
// accepted every cycle while in_stall is low. A receiver stall holds a full output
// register and the beat that waits for its read data, and raises in_stall while
// such a beat is present. cfg_wr_en writes the capacity (clipped to 1..DEPTH) and
// empties the queue; the user must use it only while no beat is in flight, as the
// block does not enforce this. Reset (rst_n low, synchronous) sets the capacity to
// 16, empties the queue and drops any beat in flight. The slot store is not
// cleared: no operation reads a slot before a push wrote it.
module ring_queue_with_front_insert #(
  parameter int DEPTH      = rqf_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rqf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration port.
  input  logic                             cfg_wr_en,
  input  logic [rqf_pkg::CNT_W-1:0]        cfg_capacity,
  // Input channel.
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_operation,
  input  logic [rqf_pkg::PORT_DATA_W-1:0]  in_item_data,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_ok,
  output logic [rqf_pkg::PORT_DATA_W-1:0]  out_front_data,
  output logic [rqf_pkg::CNT_W-1:0]        out_entry_count,
  output logic                             out_is_empty,
  output logic                             out_is_full
);

  import rqf_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Wide enough to compare an index against a capacity without overflow.
  localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  // Capacity in use after reset.
  localparam int RST_CAP = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  // Clip a capacity value to the range 1..DEPTH.
  function automatic logic [CNT_W-1:0] cap_clip(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end
    return r;
  endfunction

  // Queue state.
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  // Beat waiting for the store read data, and the output register.
  logic      p1_valid_r;
  rqf_meta_t p1_meta_r, meta_nxt;
  logic      out_valid_r;
  logic      out_ok_r;
  logic [PORT_DATA_W-1:0] out_front_r;
  logic [CNT_W-1:0]       out_count_r;
  logic      out_empty_r;
  logic      out_full_r;

  logic [CNT_W-1:0] cap_use;
  logic             accept;
  logic             p1_adv;
  rqf_op_t          op;

  // Store access.
  logic                  st_wr_en;
  logic [IDX_W-1:0]      st_wr_addr;
  logic                  st_rd_en;
  logic [IDX_W-1:0]      st_rd_addr;
  logic [DATA_WIDTH-1:0] st_rd_data;
  logic [DATA_WIDTH+PORT_DATA_W-1:0] item_wide;
  logic [DATA_WIDTH+PORT_DATA_W-1:0] front_wide;

  logic [IDX_W-1:0] rd_next;
  logic [IDX_W-1:0] rd_prev;
  logic [IDX_W-1:0] wr_next;
  logic [CMP_W-1:0] rd_plus, wr_plus;

  assign cap_use = cap_clip(cap_r);
  assign op      = rqf_op_t'(in_operation);

  // The waiting beat moves on whenever the output register is free or drains.
  assign p1_adv   = !out_valid_r || !out_stall;
  assign in_stall = p1_valid_r && !p1_adv;
  assign accept   = in_valid && !in_stall;

  // Wrapping successor and predecessor within the capacity in use.
  assign rd_plus = CMP_W'(rd_idx_r) + CMP_W'(1);
  assign wr_plus = CMP_W'(wr_idx_r) + CMP_W'(1);
  assign rd_next = (rd_plus >= CMP_W'(cap_use)) ? '0 : rd_plus[IDX_W-1:0];
  assign wr_next = (wr_plus >= CMP_W'(cap_use)) ? '0 : wr_plus[IDX_W-1:0];

  always_comb begin
    logic [CNT_W-1:0] cap_m1;
    cap_m1 = cap_use - CNT_W'(1);
    if (rd_idx_r == '0 || CMP_W'(rd_idx_r) >= CMP_W'(cap_use)) begin
      rd_prev = cap_m1[IDX_W-1:0];
    end else begin
      rd_prev = rd_idx_r - IDX_W'(1);
    end
  end

  // Fit the port word to the store width and back.
  assign item_wide  = {{DATA_WIDTH{1'b0}}, in_item_data};
  assign front_wide = {{PORT_DATA_W{1'b0}}, st_rd_data};

  // Operation decode: next queue state and the store access for this beat.
  always_comb begin
    logic [CNT_W-1:0] cap_m1;
    cap_m1       = cap_use - CNT_W'(1);
    count_nxt    = count_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    st_wr_en     = 1'b0;
    st_wr_addr   = wr_idx_r;
    st_rd_en     = 1'b0;
    st_rd_addr   = rd_next;
    meta_nxt     = '0;

    case (op)
      OP_PUSH_BACK: begin
        if (count_r < cap_use) begin
          st_wr_en    = accept;
          wr_idx_nxt  = wr_next;
          count_nxt   = count_r + CNT_W'(1);
          meta_nxt.ok = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        // The read index sits one slot before the front, so the new entry
        // goes there and the index steps back.
        if (count_r < cap_use) begin
          st_wr_en    = accept;
          st_wr_addr  = rd_idx_r;
          rd_idx_nxt  = rd_prev;
          count_nxt   = count_r + CNT_W'(1);
          meta_nxt.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (count_r != '0) begin
          st_rd_en        = accept;
          rd_idx_nxt      = rd_next;
          count_nxt       = count_r - CNT_W'(1);
          meta_nxt.ok     = 1'b1;
          meta_nxt.rd_hit = 1'b1;
        end
      end
      OP_PEEK: begin
        if (count_r != '0) begin
          st_rd_en        = accept;
          meta_nxt.ok     = 1'b1;
          meta_nxt.rd_hit = 1'b1;
        end
      end
      OP_DROP: begin
        if (count_r != '0) begin
          rd_idx_nxt  = rd_next;
          count_nxt   = count_r - CNT_W'(1);
          meta_nxt.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_nxt   = '0;
        wr_idx_nxt  = '0;
        rd_idx_nxt  = cap_m1[IDX_W-1:0];
        meta_nxt.ok = 1'b1;
      end
      default: begin
        // Unused codes leave the queue as it is and report a refusal.
      end
    endcase

    meta_nxt.count = count_nxt;
    meta_nxt.empty = (count_nxt == '0);
    meta_nxt.full  = (count_nxt == cap_use);
  end

  // Queue state registers. A capacity write also empties the queue.
  always_ff @(posedge clk) begin
    logic [CNT_W-1:0] cfg_m1;
    cfg_m1 = cap_clip(cfg_capacity) - CNT_W'(1);
    if (!rst_n) begin
      cap_r    <= CNT_W'(CAP_RESET);
      count_r  <= '0;
      wr_idx_r <= '0;
      rd_idx_r <= IDX_W'(RST_CAP - 1);
    end else if (cfg_wr_en) begin
      cap_r    <= cfg_capacity;
      count_r  <= '0;
      wr_idx_r <= '0;
      rd_idx_r <= cfg_m1[IDX_W-1:0];
    end else if (accept) begin
      count_r  <= count_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Beat waiting for the store read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (accept) begin
      p1_valid_r <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_meta_r <= meta_nxt;
    end
  end

  // Output register. The store read data is held until the waiting beat
  // moves, since no new read starts before then.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p1_adv) begin
      out_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv && p1_valid_r) begin
      out_ok_r    <= p1_meta_r.ok;
      out_front_r <= p1_meta_r.rd_hit ? front_wide[PORT_DATA_W-1:0] : '0;
      out_count_r <= p1_meta_r.count;
      out_empty_r <= p1_meta_r.empty;
      out_full_r  <= p1_meta_r.full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_front_data  = out_front_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

  rqf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slot_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (item_wide[DATA_WIDTH-1:0]),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ring queue with push to back and push to front.
module tb_top;
  import rqf_pkg::*;

  // Operation codes that the block does not define. They must leave the queue alone.
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // Idle cycles in a row after which the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned MAX_IDLE   = 16;
  localparam int unsigned MAX_SHOWN  = 10;

  // One expected result beat.
  typedef struct packed {
    logic                   ok;
    logic [PORT_DATA_W-1:0] front;
    logic [CNT_W-1:0]       count;
    logic                   empty;
    logic                   full;
  } reply_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CNT_W-1:0]       cfg_capacity;
  logic                   in_valid;
  logic                   in_stall;
  logic [2:0]             in_operation;
  logic [PORT_DATA_W-1:0] in_item_data;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_ok;
  logic [PORT_DATA_W-1:0] out_front_data;
  logic [CNT_W-1:0]       out_entry_count;
  logic                   out_is_empty;
  logic                   out_is_full;

  ring_queue_with_front_insert dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_capacity    (cfg_capacity),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_item_data    (in_item_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_front_data  (out_front_data),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  // Free-running clock with a period of 20 time units.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The largest wait each side may draw per beat. A value of zero gives a
  // stretch of back-to-back traffic on that side.
  int unsigned tx_idle_max = MAX_IDLE;
  int unsigned rx_idle_max = MAX_IDLE;

  int unsigned mismatch_count = 0;
  reply_t      predicted_replies [$];

  // Shadow copy of the queue. The slot array starts at zero, which is harmless
  // because a slot is only ever read after a push has written it.
  logic [PORT_DATA_W-1:0] shadow_slots [0:DEPTH_DEFAULT-1];
  logic [CNT_W-1:0]       shadow_cap_reg;
  int unsigned            shadow_wr;
  int unsigned            shadow_rd;
  int unsigned            shadow_count;

  // The capacity register is clipped to 1..DEPTH before it is used.
  function automatic int unsigned cap_in_use();
    if (shadow_cap_reg == 0) return 1;
    if (shadow_cap_reg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
    return 32'(shadow_cap_reg);
  endfunction

  function automatic int unsigned slot_after(int unsigned i);
    return (i + 1 >= cap_in_use()) ? 0 : i + 1;
  endfunction

  function automatic int unsigned slot_before(int unsigned i);
    return (i == 0 || i >= cap_in_use()) ? cap_in_use() - 1 : i - 1;
  endfunction

  // Clear and a capacity write both leave the queue empty. The read index sits
  // one slot before the front, so an empty queue has it on the last slot.
  function automatic void empty_shadow();
    shadow_count = 0;
    shadow_wr    = 0;
    shadow_rd    = cap_in_use() - 1;
  endfunction

  // Applies one accepted operation to the shadow queue and records the reply
  // that the block must give for it.
  function automatic void apply_queue_op(logic [2:0] op, logic [PORT_DATA_W-1:0] data);
    reply_t      r;
    int unsigned cap;
    cap = cap_in_use();
    r   = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (shadow_count < cap) begin
          shadow_slots[shadow_wr] = data;
          shadow_wr = slot_after(shadow_wr);
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        // A front insert fills the slot just before the front and backs up.
        if (shadow_count < cap) begin
          shadow_slots[shadow_rd] = data;
          shadow_rd = slot_before(shadow_rd);
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (shadow_count > 0) begin
          shadow_rd = slot_after(shadow_rd);
          r.front   = shadow_slots[shadow_rd];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_PEEK: begin
        if (shadow_count > 0) begin
          r.front = shadow_slots[slot_after(shadow_rd)];
          r.ok    = 1'b1;
        end
      end
      OP_DROP: begin
        // Dropping moves past the front entry but reports no data.
        if (shadow_count > 0) begin
          shadow_rd = slot_after(shadow_rd);
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        empty_shadow();
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.count = shadow_count[CNT_W-1:0];
    r.empty = (shadow_count == 0);
    r.full  = (shadow_count == cap);
    predicted_replies.push_back(r);
  endfunction

  // Sends one beat. It is entered just after a falling edge and leaves just
  // after one, so that every change of the inputs falls on a falling edge. The
  // valid line is only written once per step: it is lowered for a gap or
  // raised for the new beat, never both.
  task automatic send_request(logic [2:0] op, logic [PORT_DATA_W-1:0] data);
    int unsigned gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_item_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_queue_op(op, data);
    @(negedge clk);
  endtask

  // Holds off the sender until every predicted reply has come back, then lets
  // the two-stage pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // A capacity write is only made while no beat is in flight. It also empties
  // the queue, whatever it held.
  task automatic write_capacity(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_wr_en    <= 1'b1;
    cfg_capacity <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_cap_reg = value;
    empty_shadow();
  endtask

  // Operation mix for the random traffic. The push share steers the queue
  // toward full or toward empty; clear and the undefined codes stay rare, so
  // that the queue gets the chance to fill and wrap.
  function automatic logic [2:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      if ($urandom_range(0, 1) == 1) return OP_RSVD_6;
      return OP_RSVD_7;
    end
    if (r < 5) return OP_CLEAR;
    if ($urandom_range(0, 99) < push_pct) begin
      if ($urandom_range(0, 1) == 1) return OP_PUSH_FRONT;
      return OP_PUSH_BACK;
    end
    case ($urandom_range(0, 3))
      0, 1:    return OP_POP;
      2:       return OP_PEEK;
      default: return OP_DROP;
    endcase
  endfunction

  // Mostly random words, now and then all zeros or all ones.
  function automatic logic [PORT_DATA_W-1:0] pick_data();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver. After each accepted result beat it draws a number of cycles to
  // hold out_stall high. A draw of zero keeps stall low for the next beat, and
  // stall is only written once in any step.
  initial begin : result_receiver
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        @(negedge clk);
        hold = $urandom_range(0, rx_idle_max);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Every accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin : reply_checker
    reply_t want;
    reply_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_ok, out_front_data, out_entry_count, out_is_empty, out_is_full};
      if (predicted_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result beat: ok=%0d front=%h count=%0d empty=%0d full=%0d",
                   got.ok, got.front, got.count, got.empty, got.full);
      end else begin
        want = predicted_replies.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"result mismatch: expected ok=%0d front=%h count=%0d empty=%0d ",
                      "full=%0d, got ok=%0d front=%h count=%0d empty=%0d full=%0d"},
                     want.ok, want.front, want.count, want.empty, want.full,
                     got.ok, got.front, got.count, got.empty, got.full);
        end
      end
    end
  end

  // Watchdog. Any beat accepted on either channel restarts the count; a long
  // run of cycles with no beat at all means the block has hung.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Empty queue straight after reset: every take is refused, the undefined
  // codes change nothing, and clear still succeeds.
  task automatic test_empty_after_reset();
    send_request(OP_POP, '1);
    send_request(OP_PEEK, '0);
    send_request(OP_DROP, 32'h1234_5678);
    send_request(OP_RSVD_6, '1);
    send_request(OP_RSVD_7, '1);
    send_request(OP_CLEAR, '1);
  endtask

  // Both push kinds with extreme words, then peek, pop and drop in front order.
  task automatic test_push_both_ends();
    send_request(OP_PUSH_BACK, '0);
    send_request(OP_PUSH_BACK, '1);
    send_request(OP_PUSH_FRONT, 32'h8000_0001);
    send_request(OP_PUSH_FRONT, 32'h7FFF_FFFE);
    send_request(OP_PEEK, '0);
    send_request(OP_POP, '0);
    send_request(OP_DROP, '1);
    send_request(OP_POP, '0);
    send_request(OP_CLEAR, '0);
  endtask

  // A zero capacity acts as one slot, so the second push of either kind is
  // refused as full. A write also empties a queue that still holds entries.
  task automatic test_capacity_edges();
    write_capacity(5'd0);
    send_request(OP_PUSH_FRONT, 32'hA5A5_5A5A);
    send_request(OP_PUSH_BACK, '1);
    send_request(OP_PUSH_FRONT, '1);
    send_request(OP_PEEK, '0);
    write_capacity(5'd2);
    send_request(OP_PUSH_BACK, 32'h0000_0001);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFE);
    send_request(OP_RSVD_7, '0);
    write_capacity(5'd31);
    send_request(OP_PEEK, '0);
  endtask

  // Random traffic in phases of different capacity and push share. Some
  // phases run with no idling on one side.
  task automatic test_random_traffic();
    logic [CNT_W-1:0] caps [12];
    int unsigned      pushes [12];
    caps   = '{5'd31, 5'd1, 5'd16, 5'd17, 5'd0, 5'd3, 5'd8, 5'd5, 5'd16, 5'd12, 5'd2, 5'd9};
    pushes = '{60, 50, 80, 30, 55, 65, 45, 75, 50, 35, 60, 55};
    for (int p = 0; p < 12; p++) begin
      if (p >= 8 && caps[p] == 5'd16) caps[p] = CNT_W'($urandom_range(2, 15));
      write_capacity(caps[p]);
      tx_idle_max = (p % 4 == 1) ? 0 : MAX_IDLE;
      rx_idle_max = (p % 4 == 2) ? 0 : MAX_IDLE;
      for (int i = 0; i < 125; i++) begin
        send_request(pick_op(pushes[p]), pick_data());
        // Once mid-phase the sender holds off until the pipeline is empty.
        if (p == 3 && i == 60) wait_drained();
      end
    end
    tx_idle_max = MAX_IDLE;
    rx_idle_max = MAX_IDLE;
  endtask

  // Back-to-back beats on both sides with the full capacity.
  task automatic test_back_to_back();
    write_capacity(5'd16);
    tx_idle_max = 0;
    rx_idle_max = 0;
    for (int i = 0; i < 100; i++) send_request(pick_op(55), pick_data());
    tx_idle_max = MAX_IDLE;
    rx_idle_max = MAX_IDLE;
  endtask

  // The sender stops until every reply is back, then resumes on the same queue.
  task automatic test_pause_until_drained();
    write_capacity(5'd6);
    for (int i = 0; i < 20; i++) send_request(pick_op(70), pick_data());
    wait_drained();
    for (int i = 0; i < 20; i++) send_request(pick_op(40), pick_data());
  endtask

  initial begin
    // All inputs are known from time zero. Reset is released on a falling edge
    // and is not asserted again.
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_capacity = '0;
    in_valid     = 1'b0;
    in_operation = OP_PUSH_BACK;
    in_item_data = '0;
    shadow_cap_reg = CNT_W'(CAP_RESET);
    empty_shadow();
    for (int i = 0; i < DEPTH_DEFAULT; i++) shadow_slots[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_after_reset();
    test_push_both_ends();
    test_capacity_edges();
    test_random_traffic();
    test_back_to_back();
    test_pause_until_drained();

    // Let the last replies arrive, then give a stray beat time to show up.
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rqf_pkg.sv
rtl/rqf_ram.sv
rtl/ring_queue_with_front_insert.sv
tb/tb_top.sv
